>>> rtl/sld_pkg.sv
package sld_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int PTR_W = $clog2(BUFFER_BYTES);
  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

  localparam int BYTE_W = 8;
  localparam int IDX_W = 6;
  localparam int KIND_W = 3;
  localparam int TICK_W = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  // Frame layout.
  localparam int LEN_LO_POS = 3;
  localparam int LEN_HI_POS = 4;
  localparam int CSUM_POS = 5;
  localparam int MIN_HDR = 5;
  localparam int HDR_EXTRA = 6;

  localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RST = 16'd250;
  localparam logic [BYTE_W-1:0] SYNC_VALUE_RST = 8'hA5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE = 4'd1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_BYTE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LENGTH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CHECKSUM = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STALE = 3'd4;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;
  } out_word_t;

  typedef enum logic [1:0] {
    RD_FRONT,
    RD_LEN_LO,
    RD_LEN_HI,
    RD_IDX
  } rd_sel_t;

  typedef struct packed {
    logic              idle_tick;
    logic              idle_clr;
    logic              store_clr;
    logic              push;
    logic              pop_one;
    logic              pop_total;
    logic              rd_en;
    rd_sel_t           rd_sel;
    logic              lat_len_lo;
    logic              lat_total;
    logic              idx_clr;
    logic              idx_inc;
    logic              sum_clr;
    logic              sum_acc;
    logic              ev_set;
    logic [KIND_W-1:0] ev_kind;
    logic              out_load_ev;
    logic              out_load_byte;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic full;
    logic empty;
    logic stale_hit;
    logic front_sync;
    logic short_hdr;
    logic total_big;
    logic total_short;
    logic idx_last;
    logic sum_ok;
    logic out_free;
  } status_t;

endpackage

>>> rtl/sld_datapath.sv
module sld_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sld_pkg::cmd_t                       cmd,
  output sld_pkg::status_t                    status,
  input  sld_pkg::in_word_t                   in_data,
  input  logic                                cfg_valid,
  input  logic [sld_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sld_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sld_pkg::out_word_t                  out_data
);
  import sld_pkg::*;

  logic [BYTE_W-1:0] store_r [BUFFER_BYTES];
  logic [BYTE_W-1:0] rd_data_r;

  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TICK_W-1:0] idle_r, idle_inc;
  logic [TICK_W-1:0] timeout_r;
  logic [BYTE_W-1:0] sync_r;
  logic [BYTE_W-1:0] len_lo_r;
  logic [CNT_W-1:0]  total_r;
  logic [CNT_W-1:0]  idx_r;
  logic [BYTE_W-1:0] sum_r;
  logic [BYTE_W-1:0] csum_r;
  logic [KIND_W-1:0] ev_kind_r;
  logic              out_valid_r;
  out_word_t         out_data_r;

  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [CNT_W-1:0]  rd_off;
  logic [16:0]       total_wide;
  logic              out_free;

  // Circular index: ptr below the depth, off at most the depth.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(off);
    if (s >= (CNT_W + 1)'(BUFFER_BYTES)) begin
      s = s - (CNT_W + 1)'(BUFFER_BYTES);
    end
    return s[PTR_W-1:0];
  endfunction

  always_comb begin
    case (cmd.rd_sel)
      RD_FRONT:  rd_off = '0;
      RD_LEN_LO: rd_off = CNT_W'(LEN_LO_POS);
      RD_LEN_HI: rd_off = CNT_W'(LEN_HI_POS);
      RD_IDX:    rd_off = idx_r;
      default:   rd_off = idx_r;
    endcase
  end

  assign wr_addr = wrap_add(head_r, count_r);
  assign rd_addr = wrap_add(head_r, rd_off);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      store_r[wr_addr] <= in_data.rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign idle_inc = (idle_r == '1) ? idle_r : idle_r + TICK_W'(1);
  assign total_wide = {rd_data_r, len_lo_r} + 17'(HDR_EXTRA);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    head_nxt = head_r;
    count_nxt = count_r;
    if (cmd.store_clr) begin
      count_nxt = '0;
    end else if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop_one) begin
      head_nxt = wrap_add(head_r, CNT_W'(1));
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.pop_total) begin
      head_nxt = wrap_add(head_r, total_r);
      count_nxt = count_r - total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      count_r <= '0;
      idle_r <= '0;
      timeout_r <= IDLE_TIMEOUT_RST;
      sync_r <= SYNC_VALUE_RST;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      count_r <= count_nxt;
      if (cmd.idle_clr) begin
        idle_r <= '0;
      end else if (cmd.idle_tick) begin
        idle_r <= idle_inc;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_IDLE_TIMEOUT: timeout_r <= cfg_data;
          REG_SYNC_VALUE:   sync_r <= cfg_data[BYTE_W-1:0];
          default:          ;
        endcase
      end
      if (cmd.out_load_ev || cmd.out_load_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_len_lo) begin
      len_lo_r <= rd_data_r;
    end
    if (cmd.lat_total) begin
      total_r <= CNT_W'(total_wide);
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (cmd.sum_acc) begin
      if (idx_r == CNT_W'(CSUM_POS)) begin
        csum_r <= rd_data_r;
      end else begin
        sum_r <= sum_r + rd_data_r;
      end
    end
    if (cmd.ev_set) begin
      ev_kind_r <= cmd.ev_kind;
    end
    if (cmd.out_load_ev) begin
      out_data_r <= '{kind: ev_kind_r, frame_byte: '0, byte_index: '0, last: 1'b1};
    end else if (cmd.out_load_byte) begin
      out_data_r <= '{kind: KIND_BYTE, frame_byte: rd_data_r,
                      byte_index: IDX_W'(idx_r), last: status.idx_last};
    end
  end

  always_comb begin
    status.op = in_data.op;
    status.full = (count_r >= CNT_W'(BUFFER_BYTES));
    status.empty = (count_r == '0);
    status.stale_hit = (count_r != '0) && (idle_inc > timeout_r);
    status.front_sync = (rd_data_r == sync_r);
    status.short_hdr = (count_r < CNT_W'(MIN_HDR));
    status.total_big = (total_wide > 17'(BUFFER_BYTES));
    status.total_short = (17'(count_r) < total_wide);
    status.idx_last = ((idx_r + CNT_W'(1)) == total_r);
    status.sum_ok = (~sum_r == csum_r);
    status.out_free = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

>>> rtl/sld_ctrl.sv
module sld_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sld_pkg::status_t status,
  output sld_pkg::cmd_t    cmd
);
  import sld_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_EVENT   = 11'b000_0000_0010,
    S_SCAN_RD = 11'b000_0000_0100,
    S_SCAN_CK = 11'b000_0000_1000,
    S_LEN_LO  = 11'b000_0001_0000,
    S_LEN_HI  = 11'b000_0010_0000,
    S_SUM_RD  = 11'b000_0100_0000,
    S_SUM_ACC = 11'b000_1000_0000,
    S_SUM_CK  = 11'b001_0000_0000,
    S_EMIT_RD = 11'b010_0000_0000,
    S_EMIT_WR = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_IDX;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (status.op == OP_TICK) begin
            cmd.idle_tick = 1'b1;
            if (status.stale_hit) begin
              cmd.store_clr = 1'b1;
              cmd.ev_set = 1'b1;
              cmd.ev_kind = KIND_STALE;
              state_nxt = S_EVENT;
            end
          end else begin
            cmd.idle_clr = 1'b1;
            if (status.full) begin
              cmd.store_clr = 1'b1;
              cmd.ev_set = 1'b1;
              cmd.ev_kind = KIND_OVERFLOW;
              state_nxt = S_EVENT;
            end else begin
              cmd.push = 1'b1;
              state_nxt = S_SCAN_RD;
            end
          end
        end
      end
      S_EVENT: begin
        if (status.out_free) begin
          cmd.out_load_ev = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (status.empty) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_FRONT;
          state_nxt = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (!status.front_sync) begin
          cmd.pop_one = 1'b1;
          state_nxt = S_SCAN_RD;
        end else if (status.short_hdr) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_LEN_LO;
          state_nxt = S_LEN_LO;
        end
      end
      S_LEN_LO: begin
        cmd.lat_len_lo = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_LEN_HI;
        state_nxt = S_LEN_HI;
      end
      S_LEN_HI: begin
        if (status.total_big) begin
          cmd.pop_one = 1'b1;
          cmd.ev_set = 1'b1;
          cmd.ev_kind = KIND_LENGTH;
          state_nxt = S_EVENT;
        end else if (status.total_short) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.lat_total = 1'b1;
          cmd.idx_clr = 1'b1;
          cmd.sum_clr = 1'b1;
          state_nxt = S_SUM_RD;
        end
      end
      S_SUM_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        if (status.idx_last) begin
          state_nxt = S_SUM_CK;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_SUM_RD;
        end
      end
      S_SUM_CK: begin
        if (!status.sum_ok) begin
          cmd.pop_one = 1'b1;
          cmd.ev_set = 1'b1;
          cmd.ev_kind = KIND_CHECKSUM;
          state_nxt = S_EVENT;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (status.out_free) begin
          cmd.out_load_byte = 1'b1;
          if (status.idx_last) begin
            cmd.pop_total = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/sync_length_checksum_deframer.sv
// Sequence: a tick is handled in the idle state; a stale drop then waits in S_EVENT for the
// output. A byte is pushed into the store, then the scan drops leading non-sync bytes until
// the store is empty or a sync byte leads; with a complete header the length is fetched,
// and a complete frame then gets a checksum pass and an emission pass over its bytes, the
// emission waiting on the output, all through the single store read port.
// Throughput: one word at a time, taken whenever the controller is idle; reset (synchronous,
// active low) empties the store, clears the idle count and output, and restores the timeout
// to 250 ticks and the sync value to 0xA5; store contents are kept.
module sync_length_checksum_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sld_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sld_pkg::out_word_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sld_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sld_pkg::*;

  // The controller sequences the work on each accepted word; the datapath owns the
  // circular byte store, the counters, the configuration registers and the output word.
  cmd_t    cmd;
  status_t status;

  // Configuration writes are taken in any cycle; an index past the list is ignored.
  assign cfg_ready = 1'b1;

  sld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The store is a ring addressed from the head pointer, so dropping leading bytes
  // or a whole frame only moves the head and shortens the fill count.
  sld_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sld_pkg::*;

  // Timing of the bench. The clock runs at 20 ns.
  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 9;
  // A byte that completes nothing may keep the block busy for a resync pass and a length
  // fetch, and a full frame needs a checksum pass and an emission pass over the store.
  // This pause covers the longest of these before a register write or the end of the run.
  localparam int DRAIN_CYCLES = 600;
  // The receiver holds off this long once, so that the block fills up and stalls its input.
  localparam int HOLD_CYCLES = 2000;
  // No word moves on any channel for this many cycles: the run is declared hung.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 20;
  localparam int TICK_MAX = 2 ** TICK_W - 1;
  localparam int MAX_PAYLOAD = BUFFER_BYTES - HDR_EXTRA;

  // Register indexes that the block does not implement; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Our own copy of the deframer state, advanced once per accepted input word.
  logic [BYTE_W-1:0] rx_copy [BUFFER_BYTES];
  int                held_bytes = 0;
  int                idle_count = 0;
  logic [TICK_W-1:0] timeout_copy = IDLE_TIMEOUT_RST;
  logic [BYTE_W-1:0] sync_copy = SYNC_VALUE_RST;

  // Output words predicted but not yet seen, oldest first.
  out_word_t due_words [$];
  out_word_t due;

  int err_cnt = 0;
  int sent_items = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;
  // Mirrors the level that in_valid is being driven to, so that it is only ever
  // lowered when it is high.
  bit in_hi = 1'b0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  sync_length_checksum_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Removes n bytes from the front of the store copy.
  function automatic void drop_front(int n);
    int i;
    if (n >= held_bytes) begin
      held_bytes = 0;
    end else begin
      for (i = 0; i < held_bytes - n; i++) rx_copy[i] = rx_copy[i + n];
      held_bytes -= n;
    end
  endfunction

  // Appends a predicted word behind the ones already waiting.
  function automatic void add_due(out_word_t w);
    due_words.insert(due_words.size(), w);
  endfunction

  // An event is a single word that carries only its kind and the last mark.
  function automatic void push_event(logic [KIND_W-1:0] kind);
    out_word_t ev;
    ev = '0;
    ev.kind = kind;
    ev.last = 1'b1;
    add_due(ev);
  endfunction

  // Works out what one accepted input word makes the deframer emit.
  function automatic void deframe_step(in_word_t w);
    int skip;
    int total;
    int sum;
    int i;
    out_word_t fw;
    if (w.op == OP_TICK) begin
      if (idle_count < TICK_MAX) idle_count++;
      if (held_bytes != 0 && idle_count > int'(timeout_copy)) begin
        held_bytes = 0;
        push_event(KIND_STALE);
      end
      return;
    end
    idle_count = 0;
    if (held_bytes >= BUFFER_BYTES) begin
      held_bytes = 0;
      push_event(KIND_OVERFLOW);
      return;
    end
    rx_copy[held_bytes] = w.rx_byte;
    held_bytes++;
    // Hunt for the sync byte: everything in front of it is discarded.
    skip = 0;
    while (skip < held_bytes && rx_copy[skip] != sync_copy) skip++;
    drop_front(skip);
    if (held_bytes < MIN_HDR) return;
    total = int'({rx_copy[LEN_HI_POS], rx_copy[LEN_LO_POS]}) + HDR_EXTRA;
    if (total > BUFFER_BYTES) begin
      drop_front(1);
      push_event(KIND_LENGTH);
      return;
    end
    if (held_bytes < total) return;
    sum = 0;
    for (i = 0; i < total; i++) begin
      if (i != CSUM_POS) sum += rx_copy[i];
    end
    if (8'(8'hFF - sum[7:0]) != rx_copy[CSUM_POS]) begin
      drop_front(1);
      push_event(KIND_CHECKSUM);
      return;
    end
    for (i = 0; i < total; i++) begin
      fw.kind = KIND_BYTE;
      fw.frame_byte = rx_copy[i];
      fw.byte_index = IDX_W'(i);
      fw.last = (i == total - 1);
      add_due(fw);
    end
    drop_front(total);
  endfunction

  // Offers one input word, with random idle cycles in front of it, and waits until the
  // block takes it. Valid is left high so that back-to-back words need no extra edge.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      if (in_hi) begin
        in_valid <= 1'b0;
        in_hi = 1'b0;
      end
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_hi = 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_step(w);
    sent_items++;
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b);
    in_word_t w;
    w.op = OP_BYTE;
    w.rx_byte = b;
    send_word(w);
  endtask

  // The byte field of a tick is don't-care, so it carries random bits.
  task automatic send_tick();
    in_word_t w;
    w.op = OP_TICK;
    w.rx_byte = 8'($urandom);
    send_word(w);
  endtask

  // Sends a frame with the given payload length (at most MAX_PAYLOAD) under the current
  // sync value. The checksum can be spoiled, and timer ticks can be slipped in after the
  // third byte.
  task automatic send_frame(int len, bit bad_sum, int gap_ticks);
    logic [BYTE_W-1:0] fb [BUFFER_BYTES];
    int n;
    int sum;
    int i;
    n = len + HDR_EXTRA;
    fb[0] = sync_copy;
    fb[1] = 8'($urandom);
    fb[2] = 8'($urandom);
    fb[LEN_LO_POS] = len[7:0];
    fb[LEN_HI_POS] = len[15:8];
    fb[CSUM_POS] = 8'h00;
    for (i = HDR_EXTRA; i < n; i++) fb[i] = 8'($urandom);
    sum = 0;
    for (i = 0; i < n; i++) begin
      if (i != CSUM_POS) sum += fb[i];
    end
    fb[CSUM_POS] = 8'hFF - sum[7:0];
    if (bad_sum) fb[CSUM_POS] = fb[CSUM_POS] ^ 8'($urandom_range(1, 255));
    for (i = 0; i < n; i++) begin
      send_byte(fb[i]);
      if (i == 2) repeat (gap_ticks) send_tick();
    end
  endtask

  // A header whose length field asks for more than the store can hold.
  task automatic send_bad_length(logic [15:0] len);
    send_byte(sync_copy);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  // Waits until every predicted word has arrived and the block has had time to finish
  // any work that produces no word.
  task automatic settle();
    if (in_hi) begin
      in_valid <= 1'b0;
      in_hi = 1'b0;
    end
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_IDLE_TIMEOUT) begin
      timeout_copy = data;
    end else if (idx == REG_SYNC_VALUE) begin
      sync_copy = data[BYTE_W-1:0];
    end
  endtask

  // Rewrites both registers while the block is idle. The unused upper bits of the sync
  // write carry random values, which the block must drop.
  task automatic set_regs(logic [TICK_W-1:0] t, logic [BYTE_W-1:0] s, bit spare);
    settle();
    if (spare) begin
      cfg_write(REG_SPARE_HI, '1);
      cfg_write(REG_SPARE_LO, '0);
    end
    cfg_write(REG_IDLE_TIMEOUT, t);
    cfg_write(REG_SYNC_VALUE, {8'($urandom), s});
    cfg_valid <= 1'b0;
  endtask

  // Reset values: sync 0xA5 and a timeout of 250 ticks. Stray bytes ahead of the sync
  // byte are dropped, a few ticks inside a frame leave it intact, and a partial frame
  // outlives a short run of ticks.
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(0, 1'b0, 0);
    send_frame(2, 1'b0, 3);
    send_byte(sync_copy);
    repeat (3) send_tick();
  endtask

  // Lengths just past capacity and far past it, then a spoiled checksum, then a good
  // frame that has to be found behind whatever the failures left in the store.
  task automatic test_bad_frames();
    send_bad_length(16'(MAX_PAYLOAD + 1));
    send_bad_length(16'hFFFF);
    send_frame(1, 1'b1, 0);
    send_frame(3, 1'b0, 0);
  endtask

  // Register extremes, writes to unused indexes, and the timeout boundary at small values.
  task automatic test_registers();
    set_regs(16'd0, 8'h00, 1'b1);
    send_frame(2, 1'b0, 0);
    send_tick();
    send_byte(sync_copy);
    send_tick();
    set_regs(16'd3, 8'hFF, 1'b0);
    send_frame(0, 1'b0, 3);
    send_byte(sync_copy);
    repeat (4) send_tick();
  endtask

  // A frame that fills the store completely, then a short one behind it, then enough
  // ticks to drop whatever is left.
  task automatic test_max_frame();
    send_frame(MAX_PAYLOAD, 1'b0, 0);
    send_frame(1, 1'b0, 0);
    repeat (int'(timeout_copy) + 1) send_tick();
  endtask

  // Mostly well-formed frames with random content, mixed with spoiled frames, long
  // length fields, stray bytes and bursts of ticks.
  task automatic test_random_phase(int in_pct, int out_pct);
    int stop;
    int pick;
    int len;
    logic [TICK_W-1:0] t;
    logic [BYTE_W-1:0] s;
    case ($urandom_range(3))
      0: t = '0;
      1: t = TICK_W'($urandom_range(1, 4));
      2: t = TICK_W'($urandom_range(5, TICK_MAX));
      default: t = IDLE_TIMEOUT_RST;
    endcase
    case ($urandom_range(3))
      0: s = SYNC_VALUE_RST;
      1: s = 8'h00;
      2: s = 8'hFF;
      default: s = 8'($urandom);
    endcase
    set_regs(t, s, 1'b0);
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    stop = sent_items + RANDOM_ITEMS;
    while (sent_items < stop) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(9, MAX_PAYLOAD);
      end else begin
        len = $urandom_range(0, 8);
      end
      if (pick < 60) begin
        send_frame(len, 1'b0, ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0);
      end else if (pick < 70) begin
        send_frame(len, 1'b1, 0);
      end else if (pick < 78) begin
        send_bad_length(16'($urandom_range(MAX_PAYLOAD + 1, TICK_MAX)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_tick();
      end
    end
  endtask

  // The receiver goes quiet for a long stretch while frames keep coming, so the block
  // has to stall its input until the receiver picks up again.
  task automatic test_pressure();
    set_regs(16'd0, SYNC_VALUE_RST, 1'b0);
    in_idle_pct = 0;
    out_stall_pct = 0;
    send_tick();
    hold_req = 1'b1;
    repeat (3) send_frame(8, 1'b0, 0);
  endtask

  // Receiver: checks every word it takes against the oldest prediction, then decides
  // whether to be ready at the next edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
          $display("unexpected word: kind %0d byte %02h index %0d last %0d",
                   out_data.kind, out_data.frame_byte, out_data.byte_index, out_data.last);
        end
      end else begin
        due = due_words.pop_front();
        if (out_data.kind !== due.kind || out_data.frame_byte !== due.frame_byte ||
            out_data.byte_index !== due.byte_index || out_data.last !== due.last) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("mismatch: expected kind %0d byte %02h index %0d last %0d",
                     due.kind, due.frame_byte, due.byte_index, due.last);
            $display("          actual   kind %0d byte %02h index %0d last %0d",
                     out_data.kind, out_data.frame_byte, out_data.byte_index, out_data.last);
          end
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Watchdog: any word moving on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_bad_frames();
    test_registers();
    test_max_frame();
    test_random_phase(0, 0);
    test_random_phase(87, 0);
    test_random_phase(0, 87);
    test_random_phase(16, 16);
    test_pressure();
    settle();
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sld_pkg.sv
rtl/sld_datapath.sv
rtl/sld_ctrl.sv
rtl/sync_length_checksum_deframer.sv
tb/tb_top.sv
